// File: hw/rtl/srev_pkg.sv
// shared types, constants and coefficient tables of the reverberator
`default_nettype none

package srev_pkg;

  // default geometry
  localparam int COMB_DEPTH_DEF = 2048;
  localparam int AP_DELAY_1_DEF = 512;
  localparam int AP_DELAY_2_DEF = 256;
  localparam int AP_DELAY_3_DEF = 128;
  localparam int AP_DELAY_4_DEF = 64;

  localparam int NCOMB = 6;
  localparam int NAP   = 4;

  // data and register widths
  localparam int DATA_W = 16;
  localparam int CFG_W  = 13;
  localparam int IDX_W  = 3;
  localparam int COEF_W = 14;
  localparam int PROD_W = 30;

  // register indexes
  localparam logic [IDX_W-1:0] REG_WET_MIX    = 3'd0;
  localparam logic [IDX_W-1:0] REG_COMB_FIRST = 3'd1;
  localparam logic [IDX_W-1:0] REG_COMB_LAST  = 3'd6;

  localparam logic [CFG_W-1:0] WET_MIX_RST = 13'd2048;
  localparam logic [CFG_W-1:0] WET_MIX_MAX = 13'd4096;

  // Q2.12 coefficients, floored
  localparam logic signed [COEF_W-1:0] AP_GAIN   = 14'sd3481;
  localparam logic signed [COEF_W-1:0] ONE_SIXTH = 14'sd682;
  localparam logic [COEF_W-1:0]        ONE_Q12   = 14'd4096;

  // multiplier operand selection
  typedef enum logic [2:0] {
    MUL_COMB_FB,
    MUL_COMB_SCALE,
    MUL_AP_FF,
    MUL_AP_FB,
    MUL_MIX_DRY,
    MUL_MIX_WET
  } mul_sel_t;

  // commands from controller to datapath
  typedef struct packed {
    logic             clr_en;
    logic             start;
    logic             c_rd;
    logic             c_wr;
    logic             acc_en;
    logic             a_rd;
    logic             a_t;
    logic             a_wr;
    logic             mix_hold;
    logic             out_load;
    logic             mul_en;
    mul_sel_t         mul_sel;
    logic [IDX_W-1:0] idx;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic clr_done;
    logic out_free;
  } dp_stat_t;

  // feedback gain of each comb
  function automatic logic signed [COEF_W-1:0] comb_gain(input logic [IDX_W-1:0] i);
    logic signed [COEF_W-1:0] g;
    case (i)
      3'd0:    g = 14'sd2662;
      3'd1:    g = 14'sd3072;
      3'd2:    g = 14'sd3072;
      3'd3:    g = 14'sd2703;
      3'd4:    g = 14'sd3481;
      3'd5:    g = 14'sd3317;
      default: g = 14'sd0;
    endcase
    return g;
  endfunction

  // delay of each comb after reset
  function automatic int comb_delay_rst(input int i);
    int d;
    case (i)
      0:       d = 1116;
      1:       d = 1188;
      2:       d = 1277;
      3:       d = 1356;
      4:       d = 1422;
      default: d = 1491;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/srev_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module srev_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/srev_dp.sv
// datapath: config registers, delay memories, shared multiplier, accumulators
`default_nettype none

module srev_dp
  import srev_pkg::*;
#(
  parameter int COMB_DEPTH = COMB_DEPTH_DEF,
  parameter int AP_DELAY_1 = AP_DELAY_1_DEF,
  parameter int AP_DELAY_2 = AP_DELAY_2_DEF,
  parameter int AP_DELAY_3 = AP_DELAY_3_DEF,
  parameter int AP_DELAY_4 = AP_DELAY_4_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic [IDX_W-1:0]         cfg_index,
  input  wire logic [CFG_W-1:0]         cfg_data,
  input  wire logic signed [DATA_W-1:0] sample_in,
  output logic signed [DATA_W-1:0]      sample_out,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  input  wire dp_cmd_t                  cmd,
  output dp_stat_t                      stat
);

  localparam int CWORDS  = NCOMB * COMB_DEPTH;
  localparam int CA_W    = $clog2(CWORDS);
  localparam int PTR_W   = $clog2(COMB_DEPTH);
  localparam int CNT_W   = PTR_W + 1;
  localparam int CMP_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int AP_TOT  = AP_DELAY_1 + AP_DELAY_2 + AP_DELAY_3 + AP_DELAY_4;
  localparam int AA_W    = $clog2(AP_TOT);
  localparam int CLR_LEN = (CWORDS > AP_TOT) ? CWORDS : AP_TOT;
  localparam int CLR_W   = $clog2(CLR_LEN);

  // configuration registers
  logic [CFG_W-1:0] wet_mix;
  logic [CFG_W-1:0] cdelay [NCOMB];

  // state
  logic [PTR_W-1:0]        cpos [NCOMB];
  logic [AA_W-1:0]         apos [NAP];
  logic [CLR_W-1:0]        clr_cnt;
  logic signed [DATA_W-1:0] x;
  logic signed [DATA_W-1:0] acc;
  logic signed [DATA_W-1:0] c_reg;
  logic signed [DATA_W-1:0] t_reg;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] mix_acc;

  logic signed [COEF_W-1:0] mul_a;
  logic signed [DATA_W-1:0] mul_b;
  logic signed [DATA_W-1:0] prod_q;
  logic signed [DATA_W-1:0] c_val;
  logic signed [PROD_W-1:0] mix_sum;
  logic [DATA_W-1:0]        c_rdata;
  logic [DATA_W-1:0]        a_rdata;

  logic [CA_W-1:0]   c_addr;
  logic [CA_W-1:0]   c_waddr;
  logic              c_we;
  logic [DATA_W-1:0] c_wdata;
  logic [AA_W-1:0]   a_base;
  logic [AA_W:0]     a_len;
  logic [AA_W-1:0]   a_addr;
  logic [AA_W-1:0]   a_waddr;
  logic              a_we;
  logic [DATA_W-1:0] a_wdata;
  logic [CNT_W-1:0]  cpos_inc;
  logic [AA_W:0]     apos_inc;
  logic              clr_c_ok;
  logic              clr_a_ok;

  // floored Q.12 part of the product, wrapped
  assign prod_q  = prod[DATA_W+11:12];
  assign c_val   = x + prod_q;
  assign mix_sum = mix_acc + prod;

  // comb addressing
  assign c_addr   = CA_W'(cmd.idx) * CA_W'(COMB_DEPTH) + CA_W'(cpos[cmd.idx]);
  assign cpos_inc = {1'b0, cpos[cmd.idx]} + CNT_W'(1);

  // allpass addressing
  always_comb begin
    case (cmd.idx)
      3'd0: begin
        a_base = AA_W'(0);
        a_len  = (AA_W+1)'(AP_DELAY_1);
      end
      3'd1: begin
        a_base = AA_W'(AP_DELAY_1);
        a_len  = (AA_W+1)'(AP_DELAY_2);
      end
      3'd2: begin
        a_base = AA_W'(AP_DELAY_1 + AP_DELAY_2);
        a_len  = (AA_W+1)'(AP_DELAY_3);
      end
      default: begin
        a_base = AA_W'(AP_DELAY_1 + AP_DELAY_2 + AP_DELAY_3);
        a_len  = (AA_W+1)'(AP_DELAY_4);
      end
    endcase
  end

  assign a_addr   = a_base + apos[cmd.idx[1:0]];
  assign apos_inc = {1'b0, apos[cmd.idx[1:0]]} + (AA_W+1)'(1);

  // clearing sweep covers both memories
  assign clr_c_ok = (32'(clr_cnt) < 32'(CWORDS));
  assign clr_a_ok = (32'(clr_cnt) < 32'(AP_TOT));

  assign c_we    = cmd.c_wr | (cmd.clr_en & clr_c_ok);
  assign c_waddr = cmd.clr_en ? clr_cnt[CA_W-1:0] : c_addr;
  assign c_wdata = cmd.clr_en ? '0 : c_val;
  assign a_we    = cmd.a_wr | (cmd.clr_en & clr_a_ok);
  assign a_waddr = cmd.clr_en ? clr_cnt[AA_W-1:0] : a_addr;
  assign a_wdata = cmd.clr_en ? '0 : (acc + prod_q);

  assign stat.clr_done = (clr_cnt == CLR_W'(CLR_LEN - 1));
  assign stat.out_free = !out_valid || out_ready;

  srev_ram #(.WIDTH(DATA_W), .DEPTH(CWORDS)) u_comb_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .re    (cmd.c_rd),
    .raddr (c_addr),
    .rdata (c_rdata)
  );

  srev_ram #(.WIDTH(DATA_W), .DEPTH(AP_TOT)) u_ap_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (a_wdata),
    .re    (cmd.a_rd),
    .raddr (a_addr),
    .rdata (a_rdata)
  );

  // multiplier operand select
  always_comb begin
    case (cmd.mul_sel)
      MUL_COMB_FB: begin
        mul_a = comb_gain(cmd.idx);
        mul_b = $signed(c_rdata);
      end
      MUL_COMB_SCALE: begin
        mul_a = ONE_SIXTH;
        mul_b = c_reg;
      end
      MUL_AP_FF: begin
        mul_a = -AP_GAIN;
        mul_b = acc;
      end
      MUL_AP_FB: begin
        mul_a = AP_GAIN;
        mul_b = t_reg;
      end
      MUL_MIX_DRY: begin
        mul_a = $signed(ONE_Q12 - {1'b0, wet_mix});
        mul_b = x;
      end
      MUL_MIX_WET: begin
        mul_a = $signed({1'b0, wet_mix});
        mul_b = acc;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // configuration writes, out-of-range values dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      wet_mix <= WET_MIX_RST;
      for (int i = 0; i < NCOMB; i++) begin
        cdelay[i] <= (comb_delay_rst(i) > COMB_DEPTH) ? CFG_W'(COMB_DEPTH)
                                                        : CFG_W'(comb_delay_rst(i));
      end
    end else if (cfg_we) begin
      if (cfg_index == REG_WET_MIX) begin
        if (cfg_data <= WET_MIX_MAX) begin
          wet_mix <= cfg_data;
        end
      end else if (cfg_index >= REG_COMB_FIRST && cfg_index <= REG_COMB_LAST) begin
        if (cfg_data != '0 && 32'(cfg_data) <= 32'(COMB_DEPTH)) begin
          cdelay[cfg_index - REG_COMB_FIRST] <= cfg_data;
        end
      end
    end
  end

  // positions and clear counter
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NCOMB; i++) begin
        cpos[i] <= '0;
      end
      for (int i = 0; i < NAP; i++) begin
        apos[i] <= '0;
      end
      clr_cnt <= '0;
    end else begin
      if (cmd.clr_en && !stat.clr_done) begin
        clr_cnt <= clr_cnt + CLR_W'(1);
      end
      if (cmd.c_wr) begin
        cpos[cmd.idx] <= (CMP_W'(cpos_inc) >= CMP_W'(cdelay[cmd.idx])) ? '0
                                                                         : cpos_inc[PTR_W-1:0];
      end
      if (cmd.a_wr) begin
        apos[cmd.idx[1:0]] <= (apos_inc >= a_len) ? '0 : apos_inc[AA_W-1:0];
      end
    end
  end

  // arithmetic registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      x   <= sample_in;
      acc <= '0;
    end
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.c_wr) begin
      c_reg <= c_val;
    end
    if (cmd.acc_en) begin
      acc <= acc + prod_q;
    end
    if (cmd.a_t) begin
      t_reg <= $signed(a_rdata) + prod_q;
    end
    if (cmd.a_wr) begin
      acc <= t_reg;
    end
    if (cmd.mix_hold) begin
      mix_acc <= prod;
    end
    if (cmd.out_load) begin
      sample_out <= mix_sum[DATA_W+11:12];
    end
  end

  // output transaction register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/srev_ctrl.sv
// controller: sequences the clearing pass and each sample's steps
`default_nettype none

module srev_ctrl
  import srev_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  output dp_cmd_t       cmd,
  input  wire dp_stat_t stat
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_C_RD,
    S_C_M1,
    S_C_WR,
    S_C_M2,
    S_C_AC,
    S_A_RD,
    S_A_T,
    S_A_M2,
    S_A_WR,
    S_M1,
    S_M2,
    S_OUT
  } state_t;

  state_t           state;
  logic [IDX_W-1:0] idx;

  assign in_ready = (state == S_IDLE);

  // command decode
  always_comb begin
    cmd     = '0;
    cmd.idx = idx;
    unique case (state)
      S_CLEAR: cmd.clr_en = 1'b1;
      S_IDLE:  cmd.start  = in_valid;
      S_C_RD:  cmd.c_rd   = 1'b1;
      S_C_M1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_COMB_FB;
      end
      S_C_WR:  cmd.c_wr   = 1'b1;
      S_C_M2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_COMB_SCALE;
      end
      S_C_AC:  cmd.acc_en = 1'b1;
      S_A_RD: begin
        cmd.a_rd    = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_AP_FF;
      end
      S_A_T:   cmd.a_t    = 1'b1;
      S_A_M2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_AP_FB;
      end
      S_A_WR:  cmd.a_wr   = 1'b1;
      S_M1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_MIX_DRY;
      end
      S_M2: begin
        cmd.mix_hold = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_MIX_WET;
      end
      S_OUT:   cmd.out_load = stat.out_free;
      default: cmd.clr_en   = 1'b0;
    endcase
  end

  // state register and step index
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      idx   <= '0;
    end else begin
      unique case (state)
        S_CLEAR: if (stat.clr_done) state <= S_IDLE;
        S_IDLE: begin
          idx <= '0;
          if (in_valid) state <= S_C_RD;
        end
        S_C_RD:  state <= S_C_M1;
        S_C_M1:  state <= S_C_WR;
        S_C_WR:  state <= S_C_M2;
        S_C_M2:  state <= S_C_AC;
        S_C_AC: begin
          if (idx == IDX_W'(NCOMB - 1)) begin
            idx   <= '0;
            state <= S_A_RD;
          end else begin
            idx   <= idx + IDX_W'(1);
            state <= S_C_RD;
          end
        end
        S_A_RD:  state <= S_A_T;
        S_A_T:   state <= S_A_M2;
        S_A_M2:  state <= S_A_WR;
        S_A_WR: begin
          if (idx == IDX_W'(NAP - 1)) begin
            state <= S_M1;
          end else begin
            idx   <= idx + IDX_W'(1);
            state <= S_A_RD;
          end
        end
        S_M1:    state <= S_M2;
        S_M2:    state <= S_OUT;
        S_OUT:   if (stat.out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/schroeder_reverb.sv
// Schroeder reverberator top level: six feedback combs, four allpass stages and a
// dry/wet mix on signed Q4.12 samples. Each sample holds the block from acceptance
// through a step sequence for each comb, then for each allpass stage, then for the
// mix, all through one shared 14x16 multiplier and one delay memory for the combs
// and one for the allpass stages. A sample is taken only while the block is idle,
// so the next one waits until the last result has gone into the output register.
// A new sample is taken while the last result still waits in the output register.
// After reset a clearing pass over max(6*COMB_DEPTH, total allpass delay) addresses
// (12288 by default) zeroes the delay memories before the first sample is taken;
// configuration writes are taken at any time, and values out of range are dropped.
`default_nettype none

module schroeder_reverb
  import srev_pkg::*;
#(
  parameter int COMB_DEPTH = COMB_DEPTH_DEF,
  parameter int AP_DELAY_1 = AP_DELAY_1_DEF,
  parameter int AP_DELAY_2 = AP_DELAY_2_DEF,
  parameter int AP_DELAY_3 = AP_DELAY_3_DEF,
  parameter int AP_DELAY_4 = AP_DELAY_4_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic [IDX_W-1:0]         cfg_index,
  input  wire logic [CFG_W-1:0]         cfg_data,
  input  wire logic signed [DATA_W-1:0] sample_in,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  output logic signed [DATA_W-1:0]      sample_out,
  output logic                          out_valid,
  input  wire logic                     out_ready
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  srev_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  // arithmetic and storage
  srev_dp #(
    .COMB_DEPTH (COMB_DEPTH),
    .AP_DELAY_1 (AP_DELAY_1),
    .AP_DELAY_2 (AP_DELAY_2),
    .AP_DELAY_3 (AP_DELAY_3),
    .AP_DELAY_4 (AP_DELAY_4)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sample_in  (sample_in),
    .sample_out (sample_out),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

`default_nettype wire

// File: tb/schroeder_reverb_tb.sv
// self-checking testbench of the schroeder reverberator with a bit-exact predictor
`timescale 1ns / 1ps

import srev_pkg::*;

// predicts every mixed sample and checks the block's results against it
class reverb_scoreboard;
  int unsigned wet;
  int unsigned delay_len[NCOMB];
  logic signed [DATA_W-1:0] comb_mem[NCOMB][COMB_DEPTH_DEF];
  int unsigned comb_pos[NCOMB];
  logic signed [DATA_W-1:0] ap_mem[NAP][AP_DELAY_1_DEF];
  int unsigned ap_pos[NAP];
  int unsigned ap_len[NAP];
  logic signed [DATA_W-1:0] expected_q[$];
  int fails;

  function new();
    wet = 2048;
    ap_len = '{AP_DELAY_1_DEF, AP_DELAY_2_DEF, AP_DELAY_3_DEF, AP_DELAY_4_DEF};
    for (int i = 0; i < NCOMB; i++) begin
      delay_len[i] = comb_delay_rst(i);
      comb_pos[i] = 0;
      for (int j = 0; j < COMB_DEPTH_DEF; j++) comb_mem[i][j] = '0;
    end
    for (int i = 0; i < NAP; i++) begin
      ap_pos[i] = 0;
      for (int j = 0; j < AP_DELAY_1_DEF; j++) ap_mem[i][j] = '0;
    end
    fails = 0;
  endfunction

  // keep the low 16 bits as a signed value
  function longint wrap16(longint v);
    logic signed [DATA_W-1:0] s;
    s = v[DATA_W-1:0];
    return s;
  endfunction

  // register write, out-of-range values dropped
  function void note_config(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    if (idx == REG_WET_MIX) begin
      if (data <= WET_MIX_MAX) wet = data;
    end else if (idx >= REG_COMB_FIRST && idx <= REG_COMB_LAST) begin
      if (data >= 1 && data <= COMB_DEPTH_DEF) delay_len[idx - REG_COMB_FIRST] = data;
    end
  endfunction

  // one step of combs, allpass chain and mix
  function logic signed [DATA_W-1:0] predict_mix(logic signed [DATA_W-1:0] dry);
    longint x, sum, u, t, c, y;
    int unsigned p;
    x = dry;
    sum = 0;
    for (int i = 0; i < NCOMB; i++) begin
      p = comb_pos[i];
      if (p >= COMB_DEPTH_DEF) p = 0;
      c = wrap16(x + ((longint'(comb_gain(IDX_W'(i))) * longint'(comb_mem[i][p])) >>> 12));
      comb_mem[i][p] = c[DATA_W-1:0];
      p = p + 1;
      comb_pos[i] = (p >= delay_len[i]) ? 0 : p;
      sum += wrap16((c * longint'(ONE_SIXTH)) >>> 12);
    end
    u = wrap16(sum);
    for (int k = 0; k < NAP; k++) begin
      p = ap_pos[k];
      if (p >= ap_len[k]) p = 0;
      t = wrap16(longint'(ap_mem[k][p]) + ((-longint'(AP_GAIN) * u) >>> 12));
      ap_mem[k][p] = DATA_W'(wrap16(u + ((longint'(AP_GAIN) * t) >>> 12)));
      p = p + 1;
      ap_pos[k] = (p >= ap_len[k]) ? 0 : p;
      u = t;
    end
    y = ((longint'(4096) - longint'(wet)) * x + longint'(wet) * u) >>> 12;
    return y[DATA_W-1:0];
  endfunction

  function void note_sample(logic signed [DATA_W-1:0] dry);
    expected_q.push_back(predict_mix(dry));
  endfunction

  function void check_sample(logic signed [DATA_W-1:0] actual);
    logic signed [DATA_W-1:0] exp_val;
    if (expected_q.size() == 0) begin
      $error("sample_out expected none actual %0d", actual);
      fails++;
    end else begin
      exp_val = expected_q.pop_front();
      if (exp_val !== actual) begin
        $error("sample_out expected %0d actual %0d", exp_val, actual);
        fails++;
      end
    end
  endfunction
endclass

module schroeder_reverb_tb;
  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int IDLE_LIMIT = 40000;
  localparam int DRAIN_CYCLES = 80;
  localparam int HOLD_CYCLES = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic signed [DATA_W-1:0] sample_in = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [DATA_W-1:0] sample_out;
  logic out_valid;
  logic out_ready = 1'b0;

  reverb_scoreboard sb;
  bit hold_req = 1'b0;
  int idle_cycles = 0;

  schroeder_reverb DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .sample_in(sample_in), .in_valid(in_valid), .in_ready(in_ready),
    .sample_out(sample_out), .out_valid(out_valid), .out_ready(out_ready)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // register write, one cycle
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.note_config(idx, data);
  endtask

  // offer one sample with a random gap ahead of it
  task automatic send_sample(logic signed [DATA_W-1:0] v);
    int gap;
    gap = $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    sample_in <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_sample(v);
    @(negedge clk);
  endtask

  // random sample, mostly full range, sometimes quiet
  task automatic send_random(int count);
    logic signed [DATA_W-1:0] v;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) < 7) v = DATA_W'($urandom);
      else v = DATA_W'($signed($urandom_range(0, 4095)) - 2048);
      send_sample(v);
    end
  endtask

  // wait until every expected result has come, then let the pipeline settle
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_delays(int lo, int hi);
    for (int i = 0; i < NCOMB; i++)
      write_reg(IDX_W'(REG_COMB_FIRST + i), CFG_W'($urandom_range(lo, hi)));
  endtask

  // result side: random stalls, long hold-off on request
  initial begin
    int stall;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_sample(sample_out);
    end
  end

  // main sequence
  initial begin
    logic signed [DATA_W-1:0] directed[$];
    sb = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: field extremes and patterns at reset settings
    directed = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff, 16'sh0001, 16'sh4000,
                 16'shc000, 16'sh1000, 16'shf000, 16'sh5555, 16'shaaaa, 16'sh7fff,
                 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh0000, 16'sh00ff, 16'shff00};
    foreach (directed[i]) send_sample(directed[i]);
    drain();

    // dry only, shortest combs
    write_reg(REG_WET_MIX, 13'd0);
    for (int i = 0; i < NCOMB; i++) write_reg(IDX_W'(REG_COMB_FIRST + i), 13'd1);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_random(150);
    drain();

    // wet only, longest combs
    write_reg(REG_WET_MIX, WET_MIX_MAX);
    for (int i = 0; i < NCOMB; i++)
      write_reg(IDX_W'(REG_COMB_FIRST + i), CFG_W'(COMB_DEPTH_DEF));
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_random(300);
    drain();

    // dropped writes: mix and delays out of range, unknown index
    write_reg(REG_WET_MIX, 13'd4097);
    write_reg(REG_WET_MIX, 13'h1fff);
    write_reg(REG_COMB_FIRST, 13'd0);
    write_reg(IDX_W'(REG_COMB_FIRST + 1), 13'd2049);
    write_reg(REG_COMB_LAST, 13'h1fff);
    write_reg(REG_UNUSED, 13'h1fff);
    write_reg(REG_UNUSED, 13'd0);
    send_random(100);
    drain();

    // shortened delays while positions sit far out, with a long output hold-off
    write_reg(REG_WET_MIX, CFG_W'($urandom_range(0, 4096)));
    write_delays(1, 64);
    hold_req = 1'b1;
    send_random(300);
    drain();

    // several random settings
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_WET_MIX, CFG_W'($urandom_range(0, 4096)));
      if (ph[0]) write_delays(1, 300);
      else write_delays(1, COMB_DEPTH_DEF);
      send_random(210);
      drain();
    end

    if (sb.fails == 0 && sb.expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// File: filelist.f
hw/rtl/srev_pkg.sv
hw/rtl/srev_ram.sv
hw/rtl/srev_dp.sv
hw/rtl/srev_ctrl.sv
hw/rtl/schroeder_reverb.sv
tb/schroeder_reverb_tb.sv
